@@ sv/btgc_pkg.sv @@
// Shared types, constants and helpers for the button tap gesture classifier.
// No dependencies; every other file in the block imports this package.
package btgc_pkg;

  // Counter width of the gesture tracker.
  localparam int CNT_W = 16;
  // Width of the length fields in the result.
  localparam int LEN_W = 16;
  // Width used when a counter is compared against a 16-bit register.
  localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int THR_W      = 7;

  localparam logic [CFG_IDX_W-1:0] REG_STICK_THRESHOLD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_LENGTH        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_TAP_WINDOW = 2'd2;

  localparam logic [THR_W-1:0] RST_STICK_THRESHOLD   = 7'd50;
  localparam logic [15:0]      RST_TAP_LENGTH        = 16'd10;
  localparam logic [15:0]      RST_DOUBLE_TAP_WINDOW = 16'd10;

  // Fire event codes.
  localparam logic [2:0] EV_NONE   = 3'd0;
  localparam logic [2:0] EV_SINGLE = 3'd1;
  localparam logic [2:0] EV_DOWN   = 3'd2;
  localparam logic [2:0] EV_DOUBLE = 3'd3;
  localparam logic [2:0] EV_UP     = 3'd4;

  // Queue between the front and back parts.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0]        buttons;
    logic signed [7:0] hat_x;
    logic signed [7:0] hat_y;
    logic signed [7:0] stick_x;
    logic signed [7:0] stick_y;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       button_mask;
    logic [7:0]       direction_mask;
    logic [2:0]       fire_event;
    logic [LEN_W-1:0] hold_length;
    logic [LEN_W-1:0] last_press_length;
  } out_item_t;

  // Classified tick as it waits in the queue.
  typedef struct packed {
    logic [7:0] buttons;
    logic [7:0] dir;
  } cls_item_t;

  typedef struct packed {
    logic [THR_W-1:0] stick_threshold;
    logic [15:0]      tap_length;
    logic [15:0]      double_tap_window;
  } cfg_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
  endfunction

endpackage

@@ sv/btgc_front.sv @@
// Front part: accepts polling ticks and builds the direction mask.
// Depends on btgc_pkg; feeds btgc_queue.
module btgc_front (
  input  logic                in_valid,
  output logic                in_stall,
  input  btgc_pkg::in_item_t  in_data,
  input  btgc_pkg::cfg_t      cfg,
  output logic                q_valid,
  input  logic                q_stall,
  output btgc_pkg::cls_item_t q_item
);
  import btgc_pkg::*;

  logic signed [THR_W+1:0] thr_pos;
  logic signed [THR_W+1:0] thr_neg;
  logic signed [THR_W+1:0] sx;
  logic signed [THR_W+1:0] sy;
  logic [7:0]              dir;

  assign thr_pos = $signed({2'b00, cfg.stick_threshold});
  assign thr_neg = -thr_pos;
  assign sx      = (THR_W + 2)'(in_data.stick_x);
  assign sy      = (THR_W + 2)'(in_data.stick_y);

  always_comb begin
    dir[0] = in_data.hat_x < 0;
    dir[1] = in_data.hat_x > 0;
    dir[2] = in_data.hat_y < 0;
    dir[3] = in_data.hat_y > 0;
    dir[4] = sy < thr_neg;
    dir[5] = sy > thr_pos;
    dir[6] = sx < thr_neg;
    dir[7] = sx > thr_pos;
  end

  assign q_valid        = in_valid;
  assign in_stall       = q_stall;
  assign q_item.buttons = in_data.buttons;
  assign q_item.dir     = dir;

endmodule

@@ sv/btgc_queue.sv @@
// Short queue of classified ticks between the front and back parts.
// Depends on btgc_pkg.
module btgc_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  output logic                push_stall,
  input  btgc_pkg::cls_item_t push_item,
  output logic                pop_valid,
  input  logic                pop_ready,
  output btgc_pkg::cls_item_t pop_item
);
  import btgc_pkg::*;

  cls_item_t         slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] cnt;
  logic              push;
  logic              pop;

  assign push_stall = (cnt == QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (cnt != '0);
  assign pop_item   = slots[rd_ptr];
  assign push       = push_valid && !push_stall;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue fill count beyond depth");

  a_cnt_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> cnt != '0)
    else $error("queue empty right after a push");

endmodule

@@ sv/btgc_back.sv @@
// Back part: fire-button gesture tracker and the result register.
// Depends on btgc_pkg; drains btgc_queue.
module btgc_back (
  input  logic                 clk,
  input  logic                 rst,
  input  btgc_pkg::cfg_t       cfg,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  btgc_pkg::cls_item_t  q_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output btgc_pkg::out_item_t  out_data
);
  import btgc_pkg::*;

  logic             fire_was_down;
  logic [CNT_W-1:0] press_ticks;
  logic             tap_pending;
  logic [CNT_W-1:0] tap_age;
  logic [CNT_W-1:0] held_ticks;
  logic [CNT_W-1:0] last_press_ticks;

  logic             tap_pending_next;
  logic [CNT_W-1:0] press_ticks_next;
  logic [CNT_W-1:0] tap_age_next;
  logic [CNT_W-1:0] held_ticks_next;
  logic [CNT_W-1:0] last_press_ticks_next;
  logic [2:0]       ev;
  logic [CNT_W-1:0] age_inc;
  logic             expired;
  logic             fire;
  logic             take;

  // The result register frees up in the same cycle it is drained.
  assign q_ready = !out_valid || !out_stall;
  assign take    = q_valid && q_ready;
  assign fire    = q_item.buttons[0];

  always_comb begin
    age_inc               = tap_pending ? sat_inc(tap_age) : tap_age;
    expired               = tap_pending &&
                            (CMP_W'(age_inc) > CMP_W'(cfg.double_tap_window));
    tap_pending_next      = tap_pending;
    tap_age_next          = age_inc;
    press_ticks_next      = press_ticks;
    held_ticks_next       = held_ticks;
    last_press_ticks_next = last_press_ticks;
    ev                    = EV_NONE;
    if (expired) begin
      // A pending tap that timed out masks any fire edge in this tick.
      tap_pending_next = 1'b0;
      tap_age_next     = '0;
      ev               = EV_SINGLE;
    end else if (fire && !fire_was_down) begin
      press_ticks_next = '0;
      ev               = EV_DOWN;
    end else if (fire && fire_was_down) begin
      held_ticks_next  = press_ticks;
      press_ticks_next = sat_inc(press_ticks);
    end else if (!fire && fire_was_down) begin
      last_press_ticks_next = press_ticks;
      held_ticks_next       = '0;
      if (CMP_W'(press_ticks) < CMP_W'(cfg.tap_length)) begin
        if (tap_pending) begin
          tap_pending_next = 1'b0;
          tap_age_next     = '0;
          ev               = EV_DOUBLE;
        end else begin
          tap_pending_next = 1'b1;
        end
      end else begin
        ev = EV_UP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fire_was_down    <= 1'b0;
      press_ticks      <= '0;
      tap_pending      <= 1'b0;
      tap_age          <= '0;
      held_ticks       <= '0;
      last_press_ticks <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (take) begin
        fire_was_down    <= fire;
        press_ticks      <= press_ticks_next;
        tap_pending      <= tap_pending_next;
        tap_age          <= tap_age_next;
        held_ticks       <= held_ticks_next;
        last_press_ticks <= last_press_ticks_next;
      end
      if (q_ready) begin
        out_valid <= q_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data.button_mask       <= q_item.buttons;
      out_data.direction_mask    <= q_item.dir;
      out_data.fire_event        <= ev;
      out_data.hold_length       <= LEN_W'(held_ticks_next);
      out_data.last_press_length <= LEN_W'(last_press_ticks_next);
    end
  end

  a_idle_timer: assert property (@(posedge clk) disable iff (rst)
    !tap_pending |-> tap_age == '0)
    else $error("tap timer running with no pending tap");

  a_up_clears_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data.fire_event == EV_UP || out_data.fire_event == EV_DOUBLE))
      |-> out_data.hold_length == '0)
    else $error("release transaction reports a nonzero hold length");

  a_down_tracks_fire: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.fire_event == EV_DOWN) |-> out_data.button_mask[0])
    else $error("fire-down transaction without the fire button set");

endmodule

@@ sv/button_tap_gesture_classifier_unit.sv @@
// Top level of the button tap gesture classifier: configuration registers,
// front classifier, queue and gesture back end. Depends on btgc_pkg,
// btgc_front, btgc_queue and btgc_back.
//
//   Channel  Handshake                Payload
//   -------  -----------------------  ------------------------------
//   in       in_valid / in_stall      in_data   (btgc_pkg::in_item_t)
//   out      out_valid / out_stall    out_data  (btgc_pkg::out_item_t)
//   cfg      cfg_we                   cfg_index, cfg_data
//
// One transaction per clock cycle is accepted and delivered when neither side
// stalls; each result passes through a queue slot and the result register.
// A four-entry queue separates the classifier from the gesture tracker, so
// input keeps flowing for four transactions while the output stalls.
// Synchronous reset clears the gesture state and the queue and loads the
// register defaults (threshold 50, tap length 10, double-tap window 10).
module button_tap_gesture_classifier_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  btgc_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output btgc_pkg::out_item_t                out_data,
  input  logic                               cfg_we,
  input  logic [btgc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [btgc_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import btgc_pkg::*;

  cfg_t      cfg;
  logic      fq_valid;
  logic      fq_stall;
  cls_item_t fq_item;
  logic      qb_valid;
  logic      qb_ready;
  cls_item_t qb_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stick_threshold   <= RST_STICK_THRESHOLD;
      cfg.tap_length        <= RST_TAP_LENGTH;
      cfg.double_tap_window <= RST_DOUBLE_TAP_WINDOW;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STICK_THRESHOLD:   cfg.stick_threshold   <= cfg_data[THR_W-1:0];
        REG_TAP_LENGTH:        cfg.tap_length        <= cfg_data[15:0];
        REG_DOUBLE_TAP_WINDOW: cfg.double_tap_window <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  btgc_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg      (cfg),
    .q_valid  (fq_valid),
    .q_stall  (fq_stall),
    .q_item   (fq_item)
  );

  btgc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_stall (fq_stall),
    .push_item  (fq_item),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_item   (qb_item)
  );

  btgc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (qb_valid),
    .q_ready   (qb_ready),
    .q_item    (qb_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for button_tap_gesture_classifier_unit.
// Depends on btgc_pkg and the RTL of the block. A tick predictor built into the bench
// computes every expected result, and random stalls exercise the valid/stall channels.
module tb;
  import btgc_pkg::*;

  // Index 3 has no register behind it; writes there must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int IDLE_PCT = 31;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  in_item_t  tick_q[$];
  out_item_t gesture_q[$];
  int        errors = 0;
  int        queued = 0;
  bit        calm = 1'b0;
  int        hold_reqs = 0;
  int        holds_done = 0;
  int        hold_left = 0;

  // Predicted configuration and gesture state.
  logic [THR_W-1:0] thr_cfg;
  logic [15:0]      tap_len_cfg;
  logic [15:0]      window_cfg;
  logic             fire_down_r;
  logic             tap_wait;
  logic [CNT_W-1:0] press_cnt;
  logic [CNT_W-1:0] since_tap;
  logic [CNT_W-1:0] held_cnt;
  logic [CNT_W-1:0] last_press;

  button_tap_gesture_classifier_unit uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Advances the predicted gesture state by one polling tick.
  function automatic out_item_t classify_tick(input in_item_t t);
    out_item_t r;
    logic      fire;
    logic      expired;
    int        thr;
    int        hx;
    int        hy;
    int        sx;
    int        sy;
    fire = t.buttons[0];
    expired = 1'b0;
    thr = int'(thr_cfg);
    hx = t.hat_x;
    hy = t.hat_y;
    sx = t.stick_x;
    sy = t.stick_y;
    r = '0;
    r.button_mask = t.buttons;
    r.direction_mask = {sx > thr, sx < -thr, sy > thr, sy < -thr,
                        hy > 0, hy < 0, hx > 0, hx < 0};
    r.fire_event = EV_NONE;
    if (tap_wait) begin
      since_tap = (&since_tap) ? since_tap : since_tap + 1'b1;
      expired = (since_tap > window_cfg);
    end
    // An expiring tap hides every fire edge in the same tick.
    if (expired) begin
      tap_wait = 1'b0;
      since_tap = '0;
      r.fire_event = EV_SINGLE;
    end else if (fire && !fire_down_r) begin
      press_cnt = '0;
      r.fire_event = EV_DOWN;
    end else if (fire && fire_down_r) begin
      held_cnt = press_cnt;
      press_cnt = (&press_cnt) ? press_cnt : press_cnt + 1'b1;
    end else if (!fire && fire_down_r) begin
      last_press = press_cnt;
      held_cnt = '0;
      if (press_cnt < tap_len_cfg) begin
        if (tap_wait) begin
          tap_wait = 1'b0;
          since_tap = '0;
          r.fire_event = EV_DOUBLE;
        end else begin
          tap_wait = 1'b1;
        end
      end else begin
        r.fire_event = EV_UP;
      end
    end
    fire_down_r = fire;
    r.hold_length = held_cnt;
    r.last_press_length = last_press;
    return r;
  endfunction

  // Axis value in -100..100, often right at the stick threshold.
  function automatic logic [7:0] pick_axis();
    int v;
    int thr;
    thr = int'(thr_cfg);
    case ($urandom_range(3))
      0: v = thr - 1 + int'($urandom_range(2));
      1: v = -thr + 1 - int'($urandom_range(2));
      default: v = int'($urandom_range(200)) - 100;
    endcase
    if (v > 100) v = 100;
    if (v < -100) v = -100;
    return v[7:0];
  endfunction

  task automatic queue_tick(input logic [7:0] b, input logic [7:0] hx, input logic [7:0] hy,
                            input logic [7:0] sx, input logic [7:0] sy);
    in_item_t t;
    t.buttons = b;
    t.hat_x = hx;
    t.hat_y = hy;
    t.stick_x = sx;
    t.stick_y = sy;
    tick_q.push_back(t);
    queued++;
  endtask

  // Queues n ticks with the fire button fixed and everything else random.
  task automatic push_run(input bit fire, input int n);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom_range(255));
      b[0] = fire;
      queue_tick(b, pick_axis(), pick_axis(), pick_axis(), pick_axis());
    end
  endtask

  // Mostly press/release pairs sized around the tap length and the double-tap
  // window, with some ticks of random button noise mixed in.
  task automatic push_gestures(input int n);
    int stop_at;
    int plen;
    int glen;
    stop_at = queued + n;
    while (queued < stop_at) begin
      if ($urandom_range(99) < 15) begin
        repeat ($urandom_range(4, 1))
          queue_tick(8'($urandom_range(255)), pick_axis(), pick_axis(), pick_axis(),
                     pick_axis());
      end else begin
        plen = $urandom_range((tap_len_cfg > 22) ? 24 : tap_len_cfg + 2, 1);
        glen = $urandom_range((window_cfg > 22) ? 24 : window_cfg + 2, 1);
        push_run(1'b1, plen);
        push_run(1'b0, glen);
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (idx)
      REG_STICK_THRESHOLD:   thr_cfg = d[THR_W-1:0];
      REG_TAP_LENGTH:        tap_len_cfg = d[15:0];
      REG_DOUBLE_TAP_WINDOW: window_cfg = d[15:0];
      default: ;
    endcase
  endtask

  // Waits until every queued tick went in and every expected result came out,
  // then lets the pipeline settle.
  task automatic wait_idle();
    do @(negedge clk);
    while (tick_q.size() != 0 || in_valid || gesture_q.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  // Sender: holds each transaction until it is taken.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        gesture_q.push_back(classify_tick(in_data));
      if (!in_valid || !in_stall) begin
        if (tick_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          in_valid <= 1'b1;
          in_data <= tick_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each transaction against the oldest expectation.
  always @(posedge clk) begin : receiver
    out_item_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (gesture_q.size() == 0) begin
          $error("result with nothing expected: %p", out_data);
          errors++;
        end else begin
          want = gesture_q.pop_front();
          if (out_data.button_mask !== want.button_mask) begin
            $error("button_mask: expected %0h, got %0h", want.button_mask,
                   out_data.button_mask);
            errors++;
          end
          if (out_data.direction_mask !== want.direction_mask) begin
            $error("direction_mask: expected %0h, got %0h", want.direction_mask,
                   out_data.direction_mask);
            errors++;
          end
          if (out_data.fire_event !== want.fire_event) begin
            $error("fire_event: expected %0d, got %0d", want.fire_event,
                   out_data.fire_event);
            errors++;
          end
          if (out_data.hold_length !== want.hold_length) begin
            $error("hold_length: expected %0d, got %0d", want.hold_length,
                   out_data.hold_length);
            errors++;
          end
          if (out_data.last_press_length !== want.last_press_length) begin
            $error("last_press_length: expected %0d, got %0d", want.last_press_length,
                   out_data.last_press_length);
            errors++;
          end
        end
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (holds_done != hold_reqs) begin
        out_stall <= 1'b1;
        hold_left <= HOLD_OFF_CYCLES;
        holds_done <= holds_done + 1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  initial begin
    thr_cfg = RST_STICK_THRESHOLD;
    tap_len_cfg = RST_TAP_LENGTH;
    window_cfg = RST_DOUBLE_TAP_WINDOW;
    fire_down_r = 1'b0;
    tap_wait = 1'b0;
    press_cnt = '0;
    since_tap = '0;
    held_cnt = '0;
    last_press = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed ticks under the reset configuration.
    queue_tick(8'hFF, -8'sd100, 8'sd100, -8'sd100, 8'sd100);
    queue_tick(8'h00, 8'sd100, -8'sd100, 8'sd100, -8'sd100);
    queue_tick(8'h01, 8'sd0, 8'sd0, 8'sd0, 8'sd0);
    // Release of the second quick press is a double tap; sticks sit on the threshold.
    queue_tick(8'hFE, -8'sd1, 8'sd1, 8'sd50, -8'sd50);
    queue_tick(8'hAA, 8'sd1, -8'sd1, -8'sd51, 8'sd51);
    // A tap whose window runs out in the very tick a new press begins.
    push_run(1'b1, 1);
    push_run(1'b0, 11);
    push_run(1'b1, 3);
    push_run(1'b0, 1);

    // Long receiver hold-off while the sender keeps offering ticks.
    hold_reqs++;
    push_gestures(120);
    wait_idle();

    write_reg(REG_STICK_THRESHOLD, 16'd0);
    write_reg(REG_TAP_LENGTH, 16'd0);
    write_reg(REG_DOUBLE_TAP_WINDOW, 16'd0);
    push_gestures(100);
    wait_idle();

    // Upper bits of the threshold write are dropped, leaving 100.
    write_reg(REG_STICK_THRESHOLD, 16'hFFE4);
    write_reg(REG_TAP_LENGTH, 16'hFFFF);
    write_reg(REG_DOUBLE_TAP_WINDOW, 16'hFFFF);
    push_gestures(100);
    wait_idle();

    write_reg(REG_SPARE, 16'($urandom_range(16'hFFFF)));
    write_reg(REG_STICK_THRESHOLD, 16'($urandom_range(100)));
    write_reg(REG_TAP_LENGTH, 16'($urandom_range(20, 1)));
    write_reg(REG_DOUBLE_TAP_WINDOW, 16'($urandom_range(20, 1)));
    push_gestures(120);
    wait_idle();

    // A long stretch with no idling on either side; a tap left pending
    // under the widest window never expires here.
    calm = 1'b1;
    write_reg(REG_STICK_THRESHOLD, 16'($urandom_range(100)));
    write_reg(REG_TAP_LENGTH, 16'd10);
    write_reg(REG_DOUBLE_TAP_WINDOW, 16'hFFFF);
    push_gestures(150);
    wait_idle();
    calm = 1'b0;

    write_reg(REG_STICK_THRESHOLD, 16'($urandom_range(100)));
    write_reg(REG_TAP_LENGTH, 16'd5);
    write_reg(REG_DOUBLE_TAP_WINDOW, 16'd3);
    hold_reqs++;
    push_gestures(130);
    wait_idle();

    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
